>>> hdl/psau_pkg.sv
// Shared types, codes and constants for the packed SIMD arithmetic unit.
package psau_pkg;

  typedef enum logic [3:0] {
    ACT_ADD   = 4'd0,
    ACT_SUB   = 4'd1,
    ACT_RSUB  = 4'd2,
    ACT_MUL   = 4'd3,
    ACT_MIN   = 4'd4,
    ACT_MAX   = 4'd5,
    ACT_ACC   = 4'd6,
    ACT_AVG   = 4'd7,
    ACT_MULHR = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    LOP_ADD = 2'd0,
    LOP_SUB = 2'd1,
    LOP_MUL = 2'd2
  } lane_op_t;

  localparam int unsigned STAGES = 4;

  localparam logic [31:0] LANE_NAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] LANE_QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] MULH_ROUND       = 32'h0000_8000;
  localparam int unsigned MULH_SHIFT       = 16;
  localparam logic [8:0]  AVG_ROUND        = 9'd1;

  function automatic logic is_fp_action(action_t a);
    return (a == ACT_ADD) || (a == ACT_SUB) || (a == ACT_RSUB) ||
           (a == ACT_MUL) || (a == ACT_ACC);
  endfunction

endpackage

>>> hdl/psau_fp_lane.sv
// One binary32 lane: add, subtract or multiply in four register stages.
module psau_fp_lane import psau_pkg::*; (
  input  logic        clk,
  input  logic [3:0]  en,
  input  lane_op_t    op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] result
);

  // stage 0: unpack, align or multiply, specials
  logic        sa, sb, eff_sub, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
  logic [7:0]  ea, eb, xa, xb, xl, xs, dexp;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb, ml, ms;
  logic [26:0] ms27, shr, ms_al;
  logic        stk;
  logic [27:0] sum28;
  logic [47:0] prod;
  logic        spec0, sign0;
  logic [31:0] spv0;
  logic signed [9:0] e0;
  logic [47:0] m0;

  assign sa = a[31];
  assign sb = b[31] ^ (op == LOP_SUB);
  assign ea = a[30:23];
  assign eb = b[30:23];
  assign fa = a[22:0];
  assign fb = b[22:0];
  assign nan_a  = (ea == 8'hFF) && (fa != 23'd0);
  assign nan_b  = (eb == 8'hFF) && (fb != 23'd0);
  assign inf_a  = (ea == 8'hFF) && (fa == 23'd0);
  assign inf_b  = (eb == 8'hFF) && (fb == 23'd0);
  assign zero_a = (a[30:0] == 31'd0);
  assign zero_b = (b[30:0] == 31'd0);
  assign ma = {(ea != 8'd0), fa};
  assign mb = {(eb != 8'd0), fb};
  assign xa = (ea == 8'd0) ? 8'd1 : ea;
  assign xb = (eb == 8'd0) ? 8'd1 : eb;
  assign eff_sub = sa ^ sb;
  assign swap = (a[30:0] < b[30:0]);
  assign xl = swap ? xb : xa;
  assign xs = swap ? xa : xb;
  assign ml = swap ? mb : ma;
  assign ms = swap ? ma : mb;
  assign dexp = xl - xs;
  assign ms27 = {ms, 3'b000};
  assign prod = ma * mb;

  always_comb begin
    if (dexp >= 8'd27) begin
      shr = 27'd0;
      stk = |ms;
    end else begin
      shr = ms27 >> dexp[4:0];
      stk = |(ms27 & ((27'd1 << dexp[4:0]) - 27'd1));
    end
    ms_al = {shr[26:1], shr[0] | stk};
    if (eff_sub) begin
      sum28 = {1'b0, ml, 3'b000} - {1'b0, ms_al};
    end else begin
      sum28 = {1'b0, ml, 3'b000} + {1'b0, ms_al};
    end
  end

  always_comb begin
    spec0 = 1'b1;
    spv0  = LANE_NAN_DEFAULT;
    if (op == LOP_MUL) begin
      sign0 = sa ^ sb;
      e0    = $signed({2'b00, xa}) + $signed({2'b00, xb}) - 10'sd126;
      m0    = prod;
    end else begin
      sign0 = swap ? sb : sa;
      e0    = $signed({2'b00, xl}) + 10'sd1;
      m0    = {sum28, 20'd0};
    end
    if (nan_a) begin
      spv0 = a | LANE_QUIET_BIT;
    end else if (nan_b) begin
      spv0 = b | LANE_QUIET_BIT;
    end else if (op == LOP_MUL) begin
      if ((inf_a && zero_b) || (zero_a && inf_b)) begin
        spv0 = LANE_NAN_DEFAULT;
      end else if (inf_a || inf_b) begin
        spv0 = {sa ^ sb, 8'hFF, 23'd0};
      end else if (zero_a || zero_b) begin
        spv0 = {sa ^ sb, 31'd0};
      end else begin
        spec0 = 1'b0;
      end
    end else begin
      if (inf_a && inf_b && eff_sub) begin
        spv0 = LANE_NAN_DEFAULT;
      end else if (inf_a) begin
        spv0 = {sa, 8'hFF, 23'd0};
      end else if (inf_b) begin
        spv0 = {sb, 8'hFF, 23'd0};
      end else if (zero_a && zero_b) begin
        spv0 = {sa & sb, 31'd0};
      end else begin
        spec0 = 1'b0;
      end
    end
  end

  logic        s1_spec, s1_sign;
  logic [31:0] s1_spv;
  logic signed [9:0] s1_e;
  logic [47:0] s1_m;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_spec <= spec0;
      s1_spv  <= spv0;
      s1_sign <= sign0;
      s1_e    <= e0;
      s1_m    <= m0;
    end
  end

  // stage 1: leading zero count
  function automatic logic [5:0] lzc48(logic [47:0] m);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  logic        s2_spec, s2_sign;
  logic [31:0] s2_spv;
  logic signed [9:0] s2_e;
  logic [47:0] s2_m;
  logic [5:0]  s2_lz;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_spec <= s1_spec;
      s2_spv  <= s1_spv;
      s2_sign <= s1_sign;
      s2_e    <= s1_e;
      s2_m    <= s1_m;
      s2_lz   <= lzc48(s1_m);
    end
  end

  // stage 2: normalise, or denormalise into the subnormal range
  logic signed [10:0] et, rsh;
  logic [10:0] lsh;
  logic [47:0] mn;
  logic        st2;
  logic [9:0]  eo;

  always_comb begin
    et  = $signed({s2_e[9], s2_e}) - $signed({5'd0, s2_lz});
    rsh = 11'sd1 - $signed({s2_e[9], s2_e});
    lsh = 11'($signed({s2_e[9], s2_e}) - 11'sd1);
    st2 = 1'b0;
    eo  = 10'd1;
    if (et >= 11'sd1) begin
      mn = s2_m << s2_lz;
      eo = et[9:0];
    end else if (s2_e >= 10'sd1) begin
      mn = s2_m << lsh[5:0];
    end else if (rsh >= 11'sd48) begin
      mn  = 48'd0;
      st2 = |s2_m;
    end else begin
      mn  = s2_m >> rsh[5:0];
      st2 = |(s2_m & ((48'd1 << rsh[5:0]) - 48'd1));
    end
  end

  logic        s3_spec, s3_sign, s3_zero, s3_st;
  logic [31:0] s3_spv;
  logic [47:0] s3_m;
  logic [9:0]  s3_eo;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_spec <= s2_spec;
      s3_spv  <= s2_spv;
      s3_sign <= s2_sign;
      s3_zero <= (s2_m == 48'd0);
      s3_st   <= st2;
      s3_m    <= mn;
      s3_eo   <= eo;
    end
  end

  // stage 3: round to nearest even, overflow to infinity
  logic [9:0]  expf;
  logic [32:0] pre, rnd;
  logic        inc;
  logic [31:0] res3;

  always_comb begin
    expf = s3_m[47] ? s3_eo : 10'd0;
    pre  = {expf, s3_m[46:24]};
    inc  = s3_m[23] & ((|s3_m[22:0]) | s3_st | s3_m[24]);
    rnd  = pre + {32'd0, inc};
    if (s3_spec) begin
      res3 = s3_spv;
    end else if (s3_zero) begin
      res3 = 32'd0;
    end else if (rnd[32:23] >= 10'd255) begin
      res3 = {s3_sign, 8'hFF, 23'd0};
    end else begin
      res3 = {s3_sign, rnd[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      result <= res3;
    end
  end

endmodule

>>> hdl/packed_simd_arith_unit.sv
// Top level of the packed SIMD arithmetic unit: stream ports, pipeline control, lanes.
//
//  Channel   Direction  Payload (low bit first)                    Accepted when
//  s_axis    in         tuser: action; tdata: src, dest            s_axis_tvalid & s_axis_tready
//  m_axis    out        tdata: dest_result                         m_axis_tvalid & m_axis_tready
//
// A request passes through four register stages to its result; one request a cycle
// is taken when the output is drained. The depth is set by the float lanes:
// align or multiply, leading zero count, normalising shift, round.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or advancing, so bubbles close up and a stalled output blocks nothing
// until all four stages are full. Reset clears the valid bits only.
module packed_simd_arith_unit import psau_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // src_operand [63:0], dest_operand [127:64]
  input  logic [3:0]   s_axis_tuser,  // action [3:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata   // dest_result [63:0]
);

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;
  action_t           act [STAGES];
  logic [63:0]       alt [STAGES];

  // a stage may load when it is empty or its contents move on
  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  action_t     in_act;
  logic [63:0] s, d;

  assign in_act = action_t'(s_axis_tuser);
  assign s = s_axis_tdata[63:0];
  assign d = s_axis_tdata[127:64];

  // float compare: true only for an ordered, strict x < y
  function automatic logic flt_lt(logic [31:0] x, logic [31:0] y);
    logic xn, yn;
    xn = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    yn = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    if (xn || yn) return 1'b0;
    if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) return 1'b0;
    if (x[31] != y[31]) return x[31];
    if (x[31]) return x[30:0] > y[30:0];
    return x[30:0] < y[30:0];
  endfunction

  // non-float result, worked out on entry and carried alongside the lanes
  logic [63:0] alt0;
  logic [8:0]  avg_sum [8];
  logic signed [31:0] mh_prod [4];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      avg_sum[i] = {1'b0, d[8*i +: 8]} + {1'b0, s[8*i +: 8]} + AVG_ROUND;
    end
    for (int i = 0; i < 4; i++) begin
      mh_prod[i] = $signed(d[16*i +: 16]) * $signed(s[16*i +: 16]) + $signed(MULH_ROUND);
    end
    case (in_act)
      ACT_MIN: begin
        alt0[31:0]  = flt_lt(s[31:0], d[31:0]) ? s[31:0] : d[31:0];
        alt0[63:32] = flt_lt(s[63:32], d[63:32]) ? s[63:32] : d[63:32];
      end
      ACT_MAX: begin
        alt0[31:0]  = flt_lt(d[31:0], s[31:0]) ? s[31:0] : d[31:0];
        alt0[63:32] = flt_lt(d[63:32], s[63:32]) ? s[63:32] : d[63:32];
      end
      ACT_AVG: begin
        for (int i = 0; i < 8; i++) alt0[8*i +: 8] = avg_sum[i][8:1];
      end
      ACT_MULHR: begin
        for (int i = 0; i < 4; i++) begin
          alt0[16*i +: 16] = mh_prod[i][MULH_SHIFT +: 16];
        end
      end
      default: begin
        alt0 = d;
      end
    endcase
  end

  // lane operands: accumulate pairs within each word, reverse sub swaps sides
  lane_op_t    lop;
  logic [31:0] la0, lb0, la1, lb1;

  always_comb begin
    lop = LOP_ADD;
    la0 = d[31:0];
    lb0 = s[31:0];
    la1 = d[63:32];
    lb1 = s[63:32];
    case (in_act)
      ACT_SUB: begin
        lop = LOP_SUB;
      end
      ACT_RSUB: begin
        lop = LOP_SUB;
        la0 = s[31:0];
        lb0 = d[31:0];
        la1 = s[63:32];
        lb1 = d[63:32];
      end
      ACT_MUL: begin
        lop = LOP_MUL;
      end
      ACT_ACC: begin
        lb0 = d[63:32];
        la1 = s[31:0];
      end
      default: begin
        lop = LOP_ADD;
      end
    endcase
  end

  logic [31:0] r0, r1;

  psau_fp_lane u_lane0 (
    .clk    (clk),
    .en     (en),
    .op     (lop),
    .a      (la0),
    .b      (lb0),
    .result (r0)
  );

  psau_fp_lane u_lane1 (
    .clk    (clk),
    .en     (en),
    .op     (lop),
    .a      (la1),
    .b      (lb1),
    .result (r1)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_axis_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // payload alongside the lanes
  always_ff @(posedge clk) begin
    if (en[0]) begin
      act[0] <= in_act;
      alt[0] <= alt0;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        act[k] <= act[k-1];
        alt[k] <= alt[k-1];
      end
    end
  end

  assign m_axis_tvalid = v[STAGES-1];
  assign m_axis_tdata  = is_fp_action(act[STAGES-1]) ? {r1, r0} : alt[STAGES-1];

  // an empty stage anywhere leaves room for a new request
  a_room_ready: assert property (@(posedge clk) disable iff (rst)
    (v != {STAGES{1'b1}}) |-> s_axis_tready)
    else $error("request refused while the pipeline has a free stage");

  // a blocked output freezes the stage behind it
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (v[STAGES-2] && v[STAGES-1] && !m_axis_tready) |=>
      (v[STAGES-2] && $stable(act[STAGES-2]) && $stable(alt[STAGES-2])))
    else $error("stage moved while the output was stalled");

  // nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result offered straight after reset");

endmodule

>>> sim/psau_checker.sv
// Checker for the packed SIMD arithmetic unit: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module psau_checker import psau_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [3:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  output int           mismatches,
  output int           pending
);

  logic [63:0] dest_queue[$];

  // Widen a binary32 pattern to binary64; subnormals are normalised.
  function automatic real single_to_real(logic [31:0] b);
    logic [63:0] d;
    int p;
    d = '0;
    d[63] = b[31];
    if (b[30:23] == 8'hFF) begin
      d[62:52] = 11'h7FF;
      d[51:29] = b[22:0];
    end else if (b[30:23] == 8'd0) begin
      if (b[22:0] != 0) begin
        p = 0;
        for (int i = 0; i < 23; i++) if (b[i]) p = i;
        d[62:52] = 11'(p - 149 + 1023);
        d[51:0] = 52'(64'(b[22:0]) << (52 - p));
      end
    end else begin
      d[62:52] = 11'(int'(b[30:23]) - 127 + 1023);
      d[51:29] = b[22:0];
    end
    return $bitstoreal(d);
  endfunction

  // Round a binary64 value to binary32, nearest even; NaN becomes the default NaN.
  function automatic logic [31:0] real_to_single(real r);
    logic [63:0] d, m, q, rem, half;
    int e, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? LANE_NAN_DEFAULT : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023;
    m = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 54) return {d[63], 31'd0};
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (e < -126) return {d[63], 31'd0} + 32'(q);
    if (q == (64'd1 << 24)) begin
      q = q >> 1;
      e++;
    end
    if (e > 127) return {d[63], 8'hFF, 23'd0};
    return {d[63], 8'(e + 127), q[22:0]};
  endfunction

  function automatic logic lane_is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  // Lane arithmetic with NaN propagation: left NaN first, then right, both quieted.
  function automatic logic [31:0] lane_calc(logic [31:0] a, logic [31:0] b, lane_op_t op);
    real x, y, z;
    if (lane_is_nan(a)) return a | LANE_QUIET_BIT;
    if (lane_is_nan(b)) return b | LANE_QUIET_BIT;
    x = single_to_real(a);
    y = single_to_real(b);
    case (op)
      LOP_ADD: z = x + y;
      LOP_SUB: z = x - y;
      default: z = x * y;
    endcase
    return real_to_single(z);
  endfunction

  // Source lane wins only when the compare holds; NaN and equality keep the destination.
  function automatic logic [31:0] lane_pick(logic [31:0] s, logic [31:0] d, logic want_max);
    real x, y;
    if (lane_is_nan(s) || lane_is_nan(d)) return d;
    x = single_to_real(s);
    y = single_to_real(d);
    if (want_max) return (x > y) ? s : d;
    return (x < y) ? s : d;
  endfunction

  function automatic logic [63:0] next_dest(logic [3:0] code, logic [63:0] s, logic [63:0] d);
    logic [63:0] r;
    logic [8:0] sum;
    logic signed [31:0] prod;
    r = d;
    case (code)
      ACT_ADD:  r = {lane_calc(d[63:32], s[63:32], LOP_ADD), lane_calc(d[31:0], s[31:0], LOP_ADD)};
      ACT_SUB:  r = {lane_calc(d[63:32], s[63:32], LOP_SUB), lane_calc(d[31:0], s[31:0], LOP_SUB)};
      ACT_RSUB: r = {lane_calc(s[63:32], d[63:32], LOP_SUB), lane_calc(s[31:0], d[31:0], LOP_SUB)};
      ACT_MUL:  r = {lane_calc(d[63:32], s[63:32], LOP_MUL), lane_calc(d[31:0], s[31:0], LOP_MUL)};
      ACT_MIN:  r = {lane_pick(s[63:32], d[63:32], 1'b0), lane_pick(s[31:0], d[31:0], 1'b0)};
      ACT_MAX:  r = {lane_pick(s[63:32], d[63:32], 1'b1), lane_pick(s[31:0], d[31:0], 1'b1)};
      ACT_ACC:  r = {lane_calc(s[31:0], s[63:32], LOP_ADD), lane_calc(d[31:0], d[63:32], LOP_ADD)};
      ACT_AVG: begin
        for (int i = 0; i < 8; i++) begin
          sum = 9'(d[8*i +: 8]) + 9'(s[8*i +: 8]) + AVG_ROUND;
          r[8*i +: 8] = sum[8:1];
        end
      end
      ACT_MULHR: begin
        for (int i = 0; i < 4; i++) begin
          prod = 32'(signed'(d[16*i +: 16])) * 32'(signed'(s[16*i +: 16])) + MULH_ROUND;
          r[16*i +: 16] = prod[MULH_SHIFT +: 16];
        end
      end
      default: r = d;
    endcase
    return r;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
  end

  assign pending = dest_queue.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        dest_queue.push_back(next_dest(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (dest_queue.size() == 0) begin
          report($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          if (m_axis_tdata !== dest_queue[0])
            report($sformatf("dest_result %h, predicted %h", m_axis_tdata, dest_queue[0]));
          void'(dest_queue.pop_front());
        end
      end
    end
  end

endmodule

>>> sim/packed_simd_arith_unit_test.sv
// Testbench top for the packed SIMD arithmetic unit: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module packed_simd_arith_unit_test import psau_pkg::*;;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // src_operand [63:0], dest_operand [127:64]
  logic [3:0]   s_axis_tuser;   // action [3:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // dest_result [63:0]
  int           mismatches;
  int           pending;

  packed_simd_arith_unit dut (.*);

  psau_checker checker_i (.*);

  // Float lane patterns that stress the corners: zeros, infinities, NaNs, subnormals.
  logic [31:0] corner_lane[12] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0001, 32'h7F80_0001, 32'hFFA0_0000, 32'h0000_0001,
    32'h807F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000, 32'h0080_0000
  };

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Pick a lane: mostly random bits, sometimes a corner, a nearby exponent or a tiny one.
  function automatic logic [31:0] pick_lane(logic [31:0] near);
    case ($urandom_range(0, 5))
      0: return corner_lane[$urandom_range(0, 11)];
      1: return {1'($urandom), near[30:23] + 8'($urandom_range(0, 3)), 23'($urandom)};
      2: return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until the unit takes it.
  task automatic send(logic [3:0] code, logic [63:0] src, logic [63:0] dst);
    logic taken;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= {dst, src};
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_random();
    logic [31:0] d0, d1;
    logic [3:0] code;
    d0 = pick_lane($urandom);
    d1 = pick_lane($urandom);
    code = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if ($urandom_range(0, 3) == 0)
      send(code, {$urandom, $urandom}, {$urandom, $urandom});
    else
      send(code, {pick_lane(d1), pick_lane(d0)}, {d1, d0});
  endtask

  // Receiver: random stalls, a stall-free stretch, and one long hold-off.
  initial begin
    int cycle;
    m_axis_tready = 1'b0;
    cycle = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle >= 600 && cycle < 900)
        m_axis_tready <= 1'b0;
      else if (cycle >= 1500 && cycle < 2500)
        m_axis_tready <= 1'b1;
      else
        m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    int waited;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_ADD;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every action against the extremes and the special lanes, then two undefined codes.
    send(ACT_ADD,   {32'h7F80_0000, 32'h7F7F_FFFF}, {32'hFF80_0000, 32'h7F7F_FFFF});
    send(ACT_SUB,   {32'h7F80_0000, 32'h3F80_0000}, {32'h7F80_0000, 32'h3F80_0000});
    send(ACT_RSUB,  {32'h8000_0000, 32'h0000_0001}, {32'h0000_0000, 32'h8000_0001});
    send(ACT_MUL,   {32'h7F80_0000, 32'h0080_0000}, {32'h0000_0000, 32'h3E80_0000});
    send(ACT_ADD,   {32'h7FC0_0001, 32'h3F80_0000}, {32'h3F80_0000, 32'h7F80_0001});
    send(ACT_SUB,   {32'h7F80_0002, 32'hFFA0_0000}, {32'hFF80_0003, 32'h3F80_0000});
    send(ACT_MIN,   {32'h8000_0000, 32'h7FC0_0000}, {32'h0000_0000, 32'h3F80_0000});
    send(ACT_MAX,   {32'h3F80_0000, 32'h4000_0000}, {32'h7FC0_0000, 32'h3F80_0000});
    send(ACT_MIN,   {32'hFF80_0000, 32'h0000_0001}, {32'h7F80_0000, 32'h8000_0001});
    send(ACT_MAX,   {32'h7F80_0000, 32'h0000_0000}, {32'hFF80_0000, 32'h8000_0000});
    send(ACT_ACC,   {32'hFF80_0000, 32'h7F80_0000}, {32'h7F7F_FFFF, 32'h7F7F_FFFF});
    send(ACT_ACC,   {32'h7FA0_0000, 32'h3F80_0000}, {32'h3F80_0000, 32'h7FA0_0000});
    send(ACT_AVG,   64'hFFFF_FFFF_FFFF_FFFF,        64'hFFFF_FFFF_FFFF_FFFF);
    send(ACT_AVG,   64'h0001_0203_FF00_8081,        64'h0000_0000_00FF_7F80);
    send(ACT_MULHR, 64'h8000_8000_7FFF_8000,        64'h8000_7FFF_7FFF_0001);
    send(ACT_MULHR, 64'h0000_FFFF_0001_4000,        64'hFFFF_FFFF_0001_4000);
    send(4'd9,      64'h1234_5678_9ABC_DEF0,        64'hFFFF_0000_FFFF_0000);
    send(4'd15,     64'h0,                          64'h8000_0000_0000_0001);

    // Random: bursts with random gaps between them.
    for (int n = 0; n < 1800; ) begin
      int burst;
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst; k++) send_random();
      n += burst;
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the pipeline depth and a margin.
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (STAGES + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
